// ===== rtl/bsc_pkg.sv =====
`default_nettype none
package bsc_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int CAL_W = 16;
  localparam int RAW_W = 16;

  localparam int TEMP_W = 14;
  localparam int DEG_W = 11;
  localparam int PRES_W = 18;
  localparam int MMHG_W = 15;

  localparam int UT1_OFFSET = 20224;
  localparam int C6_OFFSET = 50;
  localparam int C4_OFFSET = 512;
  localparam int SENS_OFFSET = 24576;
  localparam int D1_OFFSET = 7168;
  localparam int TEMP_OFFSET = 200;
  localparam int PRES_OFFSET = 2500;

  // Multiply by 0xCCCD and shift right by 19 divides by ten, by 18 divides
  // by five; both are exact over the operand ranges used here.
  localparam int RECIP_FIVE = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    REG_CAL_ONE   = 2'd0,
    REG_CAL_TWO   = 2'd1,
    REG_CAL_THREE = 2'd2,
    REG_CAL_FOUR  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
  } coef_t;

endpackage
`default_nettype wire

// ===== rtl/bsc_if.sv =====
`default_nettype none
interface bsc_sample_if import bsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] pressure_raw;
  logic [RAW_W-1:0] temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bsc_result_if import bsc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic signed [DEG_W-1:0]  temp_degrees;
  logic signed [PRES_W-1:0] pressure_tenths_mbar;
  logic signed [MMHG_W-1:0] pressure_mmhg;

  modport source (output valid, output temp_tenths, output temp_degrees,
                  output pressure_tenths_mbar, output pressure_mmhg, input ready);
  modport sink (input valid, input temp_tenths, input temp_degrees,
                input pressure_tenths_mbar, input pressure_mmhg, output ready);
endinterface
`default_nettype wire

// ===== rtl/bsc_regs.sv =====
`default_nettype none
module bsc_regs import bsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output coef_t                  coef
);

  logic [CAL_W-1:0] cal_one;
  logic [CAL_W-1:0] cal_two;
  logic [CAL_W-1:0] cal_three;
  logic [CAL_W-1:0] cal_four;
  reg_idx_t         idx;
  logic             wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_one <= '0;
      cal_two <= '0;
      cal_three <= '0;
      cal_four <= '0;
    end else if (wr) begin
      case (idx)
        REG_CAL_ONE: cal_one <= pwdata[CAL_W-1:0];
        REG_CAL_TWO: cal_two <= pwdata[CAL_W-1:0];
        REG_CAL_THREE: cal_three <= pwdata[CAL_W-1:0];
        REG_CAL_FOUR: cal_four <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CAL_ONE: prdata[CAL_W-1:0] = cal_one;
      REG_CAL_TWO: prdata[CAL_W-1:0] = cal_two;
      REG_CAL_THREE: prdata[CAL_W-1:0] = cal_three;
      REG_CAL_FOUR: prdata[CAL_W-1:0] = cal_four;
      default: prdata = '0;
    endcase
  end

  always_comb begin
    coef.c1 = cal_one[15:1];
    coef.c2 = {cal_three[5:0], cal_four[5:0]};
    coef.c3 = cal_four[15:6];
    coef.c4 = cal_three[15:6];
    coef.c5 = {cal_one[0], cal_two[15:6]};
    coef.c6 = cal_two[5:0];
  end

endmodule
`default_nettype wire

// ===== rtl/bsc_pipe.sv =====
`default_nettype none
module bsc_pipe import bsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire coef_t   coef,
  bsc_sample_if.sink   sample,
  bsc_result_if.source result
);

  localparam int NSTAGE = 7;

  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;

  // Stage 1: temperature difference and pressure offset.
  logic [16:0]        ut1;
  logic signed [17:0] dt_full;
  logic signed [17:0] d1m_full;
  logic signed [16:0] s1_dt;
  logic signed [16:0] s1_d1m;

  // Stage 2: the three products of the temperature difference.
  logic [6:0]         c6p;
  logic signed [10:0] c4m_full;
  logic signed [24:0] tprod;
  logic signed [26:0] oprod;
  logic signed [27:0] sprod;
  logic signed [24:0] s2_tprod;
  logic signed [26:0] s2_oprod;
  logic signed [27:0] s2_sprod;
  logic signed [16:0] s2_d1m;

  // Stage 3: temperature, offset and sensitivity.
  logic signed [15:0] temp_full;
  logic signed [16:0] off_full;
  logic signed [18:0] sens_full;
  logic signed [13:0] s3_temp;
  logic signed [15:0] s3_off;
  logic signed [17:0] s3_sens;
  logic signed [16:0] s3_d1m;

  // Stage 4: pressure product and temperature reciprocal product.
  logic [13:0]        tabs;
  logic signed [33:0] s4_pprod;
  logic [29:0]        s4_tmul;
  logic signed [15:0] s4_off;
  logic signed [13:0] s4_temp;

  // Stage 5: compensated pressure and whole degrees.
  logic signed [20:0] x;
  logic signed [24:0] x10;
  logic signed [19:0] pcomp_full;
  logic [DEG_W-1:0]   deg_mag;
  logic signed [17:0] s5_pcomp;
  logic signed [13:0] s5_temp;
  logic signed [10:0] s5_deg;

  // Stage 6: pressure scaled by three eighths, then divided by five.
  logic [17:0]        pabs;
  logic [19:0]        p3;
  logic [32:0]        s6_mmul;
  logic               s6_pneg;
  logic signed [17:0] s6_pcomp;
  logic signed [13:0] s6_temp;
  logic signed [10:0] s6_deg;

  logic [MMHG_W-1:0]  mm_mag;

  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || result.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample.ready = adv[1];
  assign result.valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= sample.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    ut1 = {3'b000, coef.c5, 3'b000} + 17'(UT1_OFFSET);
    dt_full = $signed({2'b00, sample.temperature_raw}) - $signed({1'b0, ut1});
    d1m_full = $signed({2'b00, sample.pressure_raw}) - 18'sd7168;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_dt <= dt_full[16:0];
      s1_d1m <= d1m_full[16:0];
    end
  end

  always_comb begin
    c6p = {1'b0, coef.c6} + 7'(C6_OFFSET);
    c4m_full = $signed({1'b0, coef.c4}) - $signed(11'(C4_OFFSET));
    tprod = s1_dt * $signed({1'b0, c6p});
    oprod = s1_dt * $signed(c4m_full[9:0]);
    sprod = s1_dt * $signed({1'b0, coef.c3});
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_tprod <= tprod;
      s2_oprod <= $signed(oprod);
      s2_sprod <= sprod;
      s2_d1m <= s1_d1m;
    end
  end

  always_comb begin
    temp_full = 16'($signed(s2_tprod[24:10])) + 16'sd200;
    off_full = $signed({1'b0, coef.c2, 2'b00}) + 17'($signed(s2_oprod[26:12]));
    sens_full = $signed({4'b0000, coef.c1}) + 19'($signed(s2_sprod[27:10]))
              + $signed(19'(SENS_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_temp <= temp_full[13:0];
      s3_off <= off_full[15:0];
      s3_sens <= sens_full[17:0];
      s3_d1m <= s2_d1m;
    end
  end

  assign tabs = s3_temp[13] ? 14'(-s3_temp) : 14'(s3_temp);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_pprod <= s3_sens * s3_d1m;
      s4_tmul <= 30'(tabs) * 30'(RECIP_FIVE);
      s4_off <= s3_off;
      s4_temp <= s3_temp;
    end
  end

  always_comb begin
    x = 21'($signed(s4_pprod[33:14])) - 21'(s4_off);
    x10 = (25'(x) <<< 3) + (25'(x) <<< 1);
    pcomp_full = $signed(x10[24:5]) + $signed(20'(PRES_OFFSET));
    deg_mag = s4_tmul[DIV10_SHIFT+DEG_W-1:DIV10_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_pcomp <= pcomp_full[17:0];
      s5_temp <= s4_temp;
      s5_deg <= s4_temp[13] ? -$signed(deg_mag) : $signed(deg_mag);
    end
  end

  always_comb begin
    pabs = s5_pcomp[17] ? 18'(-s5_pcomp) : 18'(s5_pcomp);
    p3 = {pabs, 1'b0} + {2'b00, pabs};
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_mmul <= 33'(p3[19:3]) * 33'(RECIP_FIVE);
      s6_pneg <= s5_pcomp[17];
      s6_pcomp <= s5_pcomp;
      s6_temp <= s5_temp;
      s6_deg <= s5_deg;
    end
  end

  assign mm_mag = s6_mmul[DIV5_SHIFT+MMHG_W-1:DIV5_SHIFT];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      result.temp_tenths <= s6_temp;
      result.temp_degrees <= s6_deg;
      result.pressure_tenths_mbar <= s6_pcomp;
      result.pressure_mmhg <= s6_pneg ? -$signed(mm_mag) : $signed(mm_mag);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/barometric_sensor_compensation_core.sv =====
// Barometric sensor compensation core, first order.
// The sample channel carries one raw pressure and one raw temperature word;
// the result channel returns temperature in tenths and whole degrees and
// pressure in tenths of a millibar and in mmHg, one result word per sample.
// Both channels use valid/ready; a word moves when both are high.
// The four calibration words are to be written over the APB port only while
// the core is idle; the core does not enforce this. They take effect for
// every later sample. The datapath is a seven-stage pipeline with its
// multipliers in three of the stages; it can take a new sample every cycle
// unless the pipeline is full and the receiver stalls.
// Each stage holds a valid bit and moves forward whenever the stage ahead of
// it is empty or moving, so when the receiver stalls the output stays put and
// the pipeline fills its empty stages before ready drops; nothing is lost.
// Synchronous reset empties the pipeline and clears all calibration words.
`default_nettype none
module barometric_sensor_compensation_core import bsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  bsc_sample_if.sink             sample,
  bsc_result_if.source           result
);

  coef_t coef;

  bsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  bsc_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .coef   (coef),
    .sample (sample),
    .result (result)
  );

endmodule
`default_nettype wire
